/* src/ils_pkg.sv */
package ils_pkg;

  // Store geometry.
  localparam int CAPACITY      = 64;
  localparam int ELEMENT_WIDTH = 32;
  localparam int ADDR_W        = $clog2(CAPACITY);
  localparam int LEN_W         = $clog2(CAPACITY + 1);

  // Request operation codes.
  localparam logic [2:0] OP_APPEND  = 3'd0;
  localparam logic [2:0] OP_INSERT  = 3'd1;
  localparam logic [2:0] OP_EXTRACT = 3'd2;
  localparam logic [2:0] OP_DELETE  = 3'd3;
  localparam logic [2:0] OP_SEARCH  = 3'd4;

  // Response status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef logic signed [ELEMENT_WIDTH-1:0] elem_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [6:0]  position;
    logic signed [31:0] value;
    logic [6:0]  run_length;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic signed [31:0] data_out;
    logic        found;
    logic [5:0]  found_index;
    logic [6:0]  length_now;
  } rsp_t;

  // Write port of the element store.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    elem_t             data;
  } store_wr_t;

endpackage

/* src/ils_store.sv */
module ils_store import ils_pkg::*; (
  input  logic              clk,
  input  store_wr_t         wr,
  input  logic [ADDR_W-1:0] rd_addr,
  output elem_t             rd_data
);

  elem_t mem [CAPACITY];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* src/ils_seq.sv */
module ils_seq import ils_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  req_t              req,
  output logic              idle,
  output logic              res_valid,
  output rsp_t              res,
  input  logic              res_take,
  output store_wr_t         wr,
  output logic [ADDR_W-1:0] rd_addr,
  input  elem_t             rd_data
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_XREAD  = 3'd1;
  localparam logic [2:0] S_XCAP   = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_SEARCH = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]        state;
  logic [LEN_W-1:0]  len;
  logic [2:0]        op_r;
  elem_t             value_r;
  logic [ADDR_W-1:0] pos_r;
  logic [ADDR_W-1:0] src;
  logic [ADDR_W-1:0] dst;
  logic [LEN_W-1:0]  cnt;
  logic              pend;
  logic [ADDR_W-1:0] pend_addr;
  logic              dir_up;
  logic [1:0]        status_r;
  elem_t             data_r;
  logic              found_r;
  logic [ADDR_W-1:0] fidx_r;
  logic [LEN_W:0]    run_end;

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign run_end   = {1'b0, req.position} + {1'b0, req.run_length};

  always_comb begin
    res.status      = status_r;
    res.data_out    = data_r;
    res.found       = found_r;
    res.found_index = fidx_r;
    res.length_now  = len;
  end

  // Store port control: the read address walks with src; shift writes land in the cycle after their read.
  always_comb begin
    wr.en   = 1'b0;
    wr.addr = pend_addr;
    wr.data = rd_data;
    rd_addr = src;
    case (state)
      S_IDLE: begin
        if (start && req.op == OP_APPEND && len < LEN_W'(CAPACITY)) begin
          wr.en   = 1'b1;
          wr.addr = len[ADDR_W-1:0];
          wr.data = req.value;
        end
      end
      S_SHIFT: begin
        if (pend) begin
          wr.en = 1'b1;
        end else if (cnt == '0 && op_r == OP_INSERT) begin
          // The new element lands once the upward shift is complete.
          wr.en   = 1'b1;
          wr.addr = pos_r;
          wr.data = value_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      len   <= '0;
      pend  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            status_r <= ST_OK;
            data_r   <= '0;
            found_r  <= 1'b0;
            fidx_r   <= '0;
            op_r     <= req.op;
            value_r  <= req.value;
            pos_r    <= req.position[ADDR_W-1:0];
            pend     <= 1'b0;
            state    <= S_DONE;
            case (req.op)
              OP_APPEND: begin
                if (len >= LEN_W'(CAPACITY)) begin
                  status_r <= ST_FULL;
                end else begin
                  len <= len + 1'b1;
                end
              end
              OP_INSERT: begin
                if (req.position > len) begin
                  status_r <= ST_INVALID;
                end else if (len >= LEN_W'(CAPACITY)) begin
                  status_r <= ST_FULL;
                end else begin
                  src    <= ADDR_W'(len - 1'b1);
                  dst    <= len[ADDR_W-1:0];
                  cnt    <= len - req.position;
                  dir_up <= 1'b0;
                  len    <= len + 1'b1;
                  state  <= S_SHIFT;
                end
              end
              OP_EXTRACT: begin
                if (req.position >= len) begin
                  status_r <= ST_INVALID;
                end else begin
                  src    <= req.position[ADDR_W-1:0];
                  dst    <= req.position[ADDR_W-1:0];
                  cnt    <= len - req.position - 1'b1;
                  dir_up <= 1'b1;
                  len    <= len - 1'b1;
                  state  <= S_XREAD;
                end
              end
              OP_DELETE: begin
                if (run_end > {1'b0, len}) begin
                  status_r <= ST_INVALID;
                end else begin
                  src    <= run_end[ADDR_W-1:0];
                  dst    <= req.position[ADDR_W-1:0];
                  cnt    <= len - req.position - req.run_length;
                  dir_up <= 1'b1;
                  len    <= len - req.run_length;
                  state  <= S_SHIFT;
                end
              end
              OP_SEARCH: begin
                if (req.position < len) begin
                  src   <= req.position[ADDR_W-1:0];
                  cnt   <= len - req.position;
                  state <= S_SEARCH;
                end
              end
              default: begin
                status_r <= ST_INVALID;
              end
            endcase
          end
        end
        S_XREAD: begin
          src   <= src + 1'b1;
          state <= S_XCAP;
        end
        S_XCAP: begin
          data_r <= rd_data;
          state  <= S_SHIFT;
        end
        S_SHIFT: begin
          // Each cycle reads one source entry; the following cycle writes it to its new slot.
          if (cnt != '0) begin
            src       <= dir_up ? src + 1'b1 : src - 1'b1;
            dst       <= dir_up ? dst + 1'b1 : dst - 1'b1;
            pend      <= 1'b1;
            pend_addr <= dst;
            cnt       <= cnt - 1'b1;
          end else if (pend) begin
            pend <= 1'b0;
          end else begin
            state <= S_DONE;
          end
        end
        S_SEARCH: begin
          // Compare the entry read last cycle while the next read goes out.
          if (pend && rd_data == value_r) begin
            found_r <= 1'b1;
            fidx_r  <= pend_addr;
            pend    <= 1'b0;
            state   <= S_DONE;
          end else if (cnt != '0) begin
            src       <= src + 1'b1;
            pend      <= 1'b1;
            pend_addr <= src;
            cnt       <= cnt - 1'b1;
          end else if (pend) begin
            pend <= 1'b0;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* src/indexed_list_store.sv */
// Ordered list of signed words in a 64-entry store, with a length count.
// Request channel: req_valid/req_stall carry req (op, position, value,
// run_length). Response channel: rsp_valid/rsp_stall carry rsp (status,
// data_out, found, found_index, length_now). A transfer happens on a rising
// edge with valid high and stall low.
// One request is worked on at a time; req_stall is high from acceptance until
// the sequencer has handed its response to the output register.
// Append, rejected requests and searches that start past the end go straight
// to the response; insert, delete run and search step through the entries
// they move or compare, and extract first reads and captures its entry and
// then shifts the rest down. The element store has one read and one write
// port, so one entry moves or is compared per cycle.
// The output register lets the next request be accepted while a response
// still waits; if rsp_stall stays high, the following response waits in the
// sequencer and requests stall.
// Reset empties the list at once; there is no clearing pass, and store
// contents are only read below the current length.
module indexed_list_store import ils_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  logic              idle;
  logic              res_valid;
  rsp_t              res;
  logic              res_take;
  store_wr_t         wr;
  logic [ADDR_W-1:0] rd_addr;
  elem_t             rd_data;

  assign req_stall = !idle;
  assign res_take  = res_valid && (!rsp_valid || !rsp_stall);

  ils_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (req_valid && idle),
    .req       (req),
    .idle      (idle),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take),
    .wr        (wr),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  ils_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Output register between the sequencer and the response channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      rsp <= res;
    end
  end

  // The sequencer is busy in the cycle after it takes a request.
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request accepted but block not busy afterwards");

  // The list never grows past the store size.
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.length_now <= LEN_W'(CAPACITY))
    else $error("length beyond capacity");

  // A successful search always carries an ok status.
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.found |-> rsp.status == ST_OK)
    else $error("found flagged on a failed request");

  // Only a successful extract returns data.
  a_data_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.data_out != '0 |-> rsp.status == ST_OK && !rsp.found)
    else $error("data returned on a request that is not an extract");

endmodule

/* tb/tb_top.sv */
module tb_top;
  import ils_pkg::*;

  localparam int RANDOM_ITEMS   = 950;
  localparam int QUIET_LIMIT    = 5000;
  localparam int DRAIN_CYCLES   = 80;

  // Traffic profiles for the random part.
  typedef enum int {TRAFFIC_MIXED, TRAFFIC_GROW, TRAFFIC_SHRINK} traffic_e;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  // Shadow copy of the list, advanced once per accepted request.
  elem_t shadow_list [CAPACITY];
  int    shadow_len = 0;

  req_t req_backlog [$];
  rsp_t rsp_owed [$];
  int   n_issued = 0;
  int   n_taken = 0;
  int   n_errors = 0;
  bit   calm = 1'b0;
  int unsigned req_gap = 0;
  int unsigned rsp_hold = 0;
  int unsigned quiet_cycles = 0;

  indexed_list_store dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mostly short gaps, a few long ones, none while the traffic is calm.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 90);
  endfunction

  // Applies one request to the shadow list and returns the response it earns.
  function automatic rsp_t apply_list_op(input req_t r);
    rsp_t o;
    int pos;
    int run;
    int i;
    o = '0;
    pos = r.position;
    run = r.run_length;
    case (r.op)
      OP_APPEND: begin
        if (shadow_len >= CAPACITY) begin
          o.status = ST_FULL;
        end else begin
          shadow_list[shadow_len] = r.value;
          shadow_len++;
        end
      end
      OP_INSERT: begin
        // The position check wins over the full check.
        if (pos > shadow_len) begin
          o.status = ST_INVALID;
        end else if (shadow_len >= CAPACITY) begin
          o.status = ST_FULL;
        end else begin
          for (i = shadow_len; i > pos; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[pos] = r.value;
          shadow_len++;
        end
      end
      OP_EXTRACT: begin
        if (pos >= shadow_len) begin
          o.status = ST_INVALID;
        end else begin
          o.data_out = shadow_list[pos];
          for (i = pos; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
          shadow_len--;
        end
      end
      OP_DELETE: begin
        if (pos + run > shadow_len) begin
          o.status = ST_INVALID;
        end else begin
          for (i = pos; i + run < shadow_len; i++) shadow_list[i] = shadow_list[i+run];
          shadow_len -= run;
        end
      end
      OP_SEARCH: begin
        for (i = pos; i < shadow_len; i++) begin
          if (shadow_list[i] == r.value) begin
            o.found = 1'b1;
            o.found_index = i[ADDR_W-1:0];
            break;
          end
        end
      end
      default: begin
        o.status = ST_INVALID;
      end
    endcase
    o.length_now = 7'(shadow_len);
    return o;
  endfunction

  function automatic req_t make_req(input logic [2:0] op, input int pos, input elem_t val,
                                    input int run);
    req_t r;
    r.op = op;
    r.position = 7'(pos);
    r.value = val;
    r.run_length = 7'(run);
    return r;
  endfunction

  // Extremes, a small set of repeating values, or anything at all.
  function automatic elem_t random_value();
    int unsigned r;
    r = $urandom_range(0, 15);
    case (r)
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return '0;
      3: return '1;
      4, 5, 6, 7, 8, 9: return elem_t'(32'($urandom_range(0, 7)) - 32'd4);
      default: return elem_t'($urandom);
    endcase
  endfunction

  // Builds a request that fits the current list most of the time.
  function automatic req_t random_request(input traffic_e traffic);
    req_t r;
    int len;
    int p;
    int j;
    int wa;
    int wi;
    int we;
    int wd;
    bit bad;
    len = shadow_len;
    case (traffic)
      TRAFFIC_GROW:   begin wa = 45; wi = 35; we = 5;  wd = 5;  end
      TRAFFIC_SHRINK: begin wa = 10; wi = 10; we = 30; wd = 35; end
      default:        begin wa = 20; wi = 20; we = 20; wd = 15; end
    endcase
    r.position = 7'($urandom_range(0, 127));
    r.run_length = 7'($urandom_range(0, 127));
    r.value = random_value();
    bad = ($urandom_range(0, 99) < 8);
    if ($urandom_range(0, 99) < 3) begin
      r.op = OP_SEARCH + 3'($urandom_range(1, 3));
    end else begin
      p = $urandom_range(0, 99);
      if (p < wa) r.op = OP_APPEND;
      else if (p < wa + wi) r.op = OP_INSERT;
      else if (p < wa + wi + we) r.op = OP_EXTRACT;
      else if (p < wa + wi + we + wd) r.op = OP_DELETE;
      else r.op = OP_SEARCH;
    end
    case (r.op)
      OP_INSERT: begin
        if (!bad) r.position = 7'($urandom_range(0, len));
      end
      OP_EXTRACT: begin
        if (!bad && len > 0) r.position = 7'($urandom_range(0, len - 1));
      end
      OP_DELETE: begin
        if (!bad) begin
          r.position = 7'($urandom_range(0, len));
          j = len - r.position;
          if (traffic != TRAFFIC_SHRINK && j > 4) j = 4;
          r.run_length = 7'($urandom_range(0, j));
        end
      end
      OP_SEARCH: begin
        if (!bad) begin
          if (len > 0 && $urandom_range(0, 3) != 0) begin
            j = $urandom_range(0, len - 1);
            r.value = shadow_list[j];
            if ($urandom_range(0, 3) == 0) r.position = 7'($urandom_range(0, len));
            else r.position = 7'($urandom_range(0, j));
          end else begin
            r.position = 7'($urandom_range(0, len));
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Hands one request to the driver and waits until the block has taken it.
  task automatic issue(input req_t r);
    req_backlog.push_back(r);
    n_issued++;
    do @(negedge clk); while (n_taken != n_issued);
  endtask

  task automatic check_field(input string field, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      n_errors++;
    end
  endtask

  // Request driver: predicts on acceptance, then presents the next request after a gap.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      req_gap <= 0;
    end else begin
      if (req_valid && !req_stall) begin
        rsp_owed.push_back(apply_list_op(req));
        n_taken <= n_taken + 1;
      end
      if (!req_valid || !req_stall) begin
        if (req_gap != 0) begin
          req_valid <= 1'b0;
          req_gap <= req_gap - 1;
        end else if (req_backlog.size() != 0) begin
          req <= req_backlog.pop_front();
          req_valid <= 1'b1;
          req_gap <= pick_gap();
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor: checks each accepted response and stalls at random.
  always @(posedge clk) begin : rsp_side
    rsp_t want;
    int unsigned g;
    if (rst) begin
      rsp_stall <= 1'b0;
      rsp_hold <= 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (rsp_owed.size() == 0) begin
          $error("response arrived with no request outstanding");
          n_errors++;
        end else begin
          want = rsp_owed.pop_front();
          check_field("status", 64'(want.status), 64'(rsp.status));
          check_field("data_out", 64'(want.data_out), 64'(rsp.data_out));
          check_field("found", 64'(want.found), 64'(rsp.found));
          check_field("found_index", 64'(want.found_index), 64'(rsp.found_index));
          check_field("length_now", 64'(want.length_now), 64'(rsp.length_now));
        end
      end
      if (rsp_hold != 0) begin
        rsp_stall <= 1'b1;
        rsp_hold <= rsp_hold - 1;
      end else begin
        g = pick_gap();
        rsp_stall <= (g != 0);
        rsp_hold <= (g == 0) ? 0 : g - 1;
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    traffic_e traffic;
    int phase_left;
    int n;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: empty list, extremes, boundaries and unknown codes.
    issue(make_req(OP_SEARCH, 0, '0, 0));
    issue(make_req(OP_EXTRACT, 0, '0, 0));
    issue(make_req(OP_DELETE, 0, '0, 0));
    issue(make_req(OP_DELETE, 0, '0, 1));
    issue(make_req(OP_INSERT, 1, 32'sd9, 0));
    issue(make_req(OP_APPEND, 127, 32'sh7FFFFFFF, 127));
    issue(make_req(OP_APPEND, 0, 32'sh80000000, 0));
    issue(make_req(OP_INSERT, 0, '1, 0));
    issue(make_req(OP_INSERT, 3, '0, 0));
    issue(make_req(OP_INSERT, 5, 32'sd5, 0));
    issue(make_req(OP_SEARCH + 3'd1, 0, 32'sd1, 0));
    issue(make_req(OP_SEARCH + 3'd2, 127, '1, 127));
    issue(make_req(OP_SEARCH + 3'd3, 0, '0, 0));
    issue(make_req(OP_SEARCH, 0, 32'sh80000000, 0));
    issue(make_req(OP_SEARCH, 3, 32'sh80000000, 0));
    issue(make_req(OP_SEARCH, 4, '0, 0));
    issue(make_req(OP_SEARCH, 127, '0, 0));
    issue(make_req(OP_EXTRACT, 4, '0, 0));
    issue(make_req(OP_EXTRACT, 1, '0, 0));
    issue(make_req(OP_DELETE, 1, '0, 3));
    issue(make_req(OP_DELETE, 1, '0, 1));
    issue(make_req(OP_DELETE, 2, '0, 0));
    issue(make_req(OP_EXTRACT, 1, '0, 0));
    issue(make_req(OP_DELETE, 0, '0, 1));

    // Random part in phases; the first one, of 130 requests, favours growing the list.
    n = 0;
    phase_left = 0;
    traffic = TRAFFIC_GROW;
    while (n < RANDOM_ITEMS) begin
      if (phase_left == 0) begin
        if (n != 0) traffic = traffic_e'($urandom_range(0, 2));
        phase_left = (n == 0) ? 130 : $urandom_range(40, 130);
        calm = ($urandom_range(0, 3) == 0);
      end
      issue(random_request(traffic));
      phase_left--;
      n++;
    end

    // Drain the remaining responses, then leave room for stray ones.
    while (rsp_owed.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* sim.f */
src/ils_pkg.sv
src/ils_store.sv
src/ils_seq.sv
src/indexed_list_store.sv
tb/tb_top.sv
